// ===== hw/rtl/bvam_pkg.sv =====
// ----------------------------------------------------------------------------
// bvam_pkg
// Types and constants shared by the approximate matcher modules.
// ----------------------------------------------------------------------------
package bvam_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int BLOCKS_DEF    = 4;
    localparam int ALPHABET_DEF  = 128;

    localparam int LEN_W    = 9;
    localparam int ERR_W    = 8;
    localparam int CHAR_W   = 7;
    localparam int BIDX_W   = 2;
    localparam int SCORE_W  = 10;
    localparam int CNT_W    = 34;
    localparam int POS_W    = 33;
    localparam int REQ_W    = 2;
    localparam int PADDR_W  = 3;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 10'd1023;

    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TEXT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_END  = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_LEN = 3'h0;
    localparam logic [PADDR_W-1:0] ADDR_ERR = 3'h4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_BLOCK,
        ST_DECIDE,
        ST_PAD,
        ST_OUT
    } t_state;

endpackage

// ===== hw/rtl/bit_vector_approx_matcher.sv =====
// ----------------------------------------------------------------------------
// bit_vector_approx_matcher
// Blocked bit-parallel edit-distance column over a streamed text.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in      | input     | i_valid / o_stall, req/char/block/word
//  out     | output    | o_valid / i_stall, match/position/last
//  cfg     | input     | APB write, pready tied high
//
// Text item: a table read and a block step for each active block, then a
// decide step (again for each block dropped from the active set), then the
// output, held while stalled; column blocks go in turn via the table read port.
// End item: one result per padding row, one per cycle when not stalled.
// Load: written on accept. Synchronous active-low reset; table contents undefined.
// A stalled output holds the block; input is taken once the result is out.
// ----------------------------------------------------------------------------
module bit_vector_approx_matcher
    import bvam_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int BLOCKS    = BLOCKS_DEF,
    parameter int ALPHABET  = ALPHABET_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [BIDX_W-1:0]  i_block_index,
    input  logic [63:0]        i_table_word,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_match_found,
    output logic signed [POS_W-1:0] o_text_position,
    output logic               o_last_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int DEPTH  = ALPHABET * BLOCKS;
    localparam int AW     = $clog2(DEPTH);
    localparam int BW     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CW     = $clog2(ALPHABET) > 0 ? $clog2(ALPHABET) : 1;
    localparam int PW     = $clog2(WORD_BITS + 1);
    localparam int MAXLEN = BLOCKS * WORD_BITS;
    localparam logic [WORD_BITS-1:0] MSK = '1;
    localparam logic signed [SCORE_W+1:0] CUR_ONE = (SCORE_W+2)'(1);

    // ---------------- configuration
    logic [LEN_W-1:0] r_len, n_len;
    logic [ERR_W-1:0] r_err, n_err;
    logic             cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // column init on a register write uses the value being written
    always_comb begin
        n_len = r_len;
        n_err = r_err;
        if (!i_rst_n) begin
            n_len = LEN_W'(1);
            n_err = '0;
        end else begin
            if (cfg_wr && paddr == ADDR_LEN) n_len = pwdata[LEN_W-1:0];
            if (cfg_wr && paddr == ADDR_ERR) n_err = pwdata[ERR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr)
            ADDR_LEN: prdata = {{(32-LEN_W){1'b0}}, r_len};
            ADDR_ERR: prdata = {{(32-ERR_W){1'b0}}, r_err};
            default:  prdata = '0;
        endcase
    end

    // derived figures
    logic [15:0] eff_len, used, pad, sd_init;
    always_comb begin
        eff_len = (n_len == '0) ? 16'd1 : 16'(n_len);
        if (eff_len > 16'(MAXLEN)) eff_len = 16'(MAXLEN);
        used = 16'((eff_len - 16'd1) / 16'(WORD_BITS)) + 16'd1;
        pad  = 16'(used * 16'(WORD_BITS) - eff_len);
        sd_init = (n_err == '0) ? 16'd0 : 16'((16'(n_err) - 16'd1) / 16'(WORD_BITS));
        if (sd_init > used - 16'd1) sd_init = used - 16'd1;
    end

    // ---------------- column state
    logic [WORD_BITS-1:0] r_pv [BLOCKS];
    logic [WORD_BITS-1:0] r_mv [BLOCKS];
    logic [SCORE_W-1:0]   r_sc [BLOCKS];
    logic [BW-1:0]        r_sd;
    logic [CNT_W-1:0]     r_cnt;

    // ---------------- table
    logic             tbl_we;
    logic [AW-1:0]    tbl_waddr, tbl_raddr;
    logic [WORD_BITS-1:0] tbl_rdata;

    bvam_table #(.WORD_BITS(WORD_BITS), .DEPTH(DEPTH)) u_table (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(tbl_waddr),
        .i_wdata(i_table_word[WORD_BITS-1:0]),
        .i_raddr(tbl_raddr),
        .o_rdata(tbl_rdata)
    );

    // ---------------- sequencer
    t_state r_st, n_st;
    logic [CW-1:0]  r_ch;
    logic           r_chok;
    logic [BW:0]    r_b;        // block being worked
    logic           r_pc, r_mc;
    logic [SCORE_W-1:0] r_last_old;
    logic [PW-1:0]  r_i;        // padding row index
    logic [WORD_BITS-1:0] r_p, r_m;
    logic signed [SCORE_W+1:0] r_cur;
    logic           r_act;
    logic           r_omatch, r_olast;
    logic [POS_W-1:0] r_opos;

    logic acc_in;
    assign o_stall = (r_st != ST_IDLE);
    assign acc_in  = i_valid && !o_stall;
    assign o_valid = (r_st == ST_OUT) || (r_st == ST_PAD);

    logic in_ok;
    assign in_ok = (32'(i_char_code) < ALPHABET) && (32'(i_block_index) < BLOCKS);
    assign tbl_we    = acc_in && (i_req_type == REQ_LOAD) && in_ok;
    assign tbl_waddr = AW'(32'(i_char_code) * BLOCKS + 32'(i_block_index));
    // during a block step fetch the following block's row; the grow test
    // after the last worked block needs it
    assign tbl_raddr = AW'(32'(r_ch) * BLOCKS + 32'(r_b) + 32'(r_st == ST_BLOCK));

    // word for block r_b (data read last cycle)
    logic [WORD_BITS-1:0] u_w;
    logic                 blk_ok;
    assign blk_ok = r_chok && (32'(r_b) < BLOCKS);
    assign u_w    = blk_ok ? tbl_rdata : '0;

    // one block step
    logic [WORD_BITS-1:0] bp, bm, by, bx, bu, bph, bmh, by2, npv, nmv;
    logic [BW-1:0] bi;
    always_comb begin
        bi  = r_b[BW-1:0];
        bp  = r_pv[bi];
        bm  = r_mv[bi];
        by  = u_w | WORD_BITS'(r_mc);
        bx  = ((((by & bp) + bp) & MSK) ^ bp) | by;
        bu  = u_w | bm;
        bph = bm | ~(bx | bp);
        bmh = bp & bx;
        by2 = (bph << 1) | WORD_BITS'(r_pc);
        npv = (bmh << 1) | WORD_BITS'(r_mc) | ~(bu | by2);
        nmv = by2 & bu;
    end

    // decide step values
    logic [BW:0] sd1;
    logic        grow;
    logic [SCORE_W+1:0] lim;
    assign sd1  = {1'b0, r_sd} + 1'b1;
    assign lim  = (SCORE_W+2)'(r_err) + (SCORE_W+2)'(WORD_BITS);
    assign grow = (r_last_old == SCORE_W'(r_err)) && (16'(sd1) < used) &&
                  (32'(sd1) < BLOCKS) && ((u_w[0] && blk_ok) || r_mc);

    // next-state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (acc_in && i_req_type == REQ_TEXT) n_st = ST_READ;
                else if (acc_in && i_req_type == REQ_END) begin
                    n_st = (pad == 16'd0) ? ST_IDLE : ST_PAD;
                end
            end
            ST_READ:  n_st = ST_BLOCK;
            ST_BLOCK: n_st = (r_b == {1'b0, r_sd}) ? ST_DECIDE : ST_READ;
            ST_DECIDE: n_st = (grow || r_sc[r_sd] <= SCORE_W'(lim) || r_sd == '0)
                              ? ST_OUT : ST_DECIDE;
            ST_OUT:   if (!i_stall) n_st = ST_IDLE;
            ST_PAD:   if (!i_stall && r_olast) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else r_st <= n_st;
    end

    // pad row scores for row r_i
    logic signed [SCORE_W+1:0] pad_cur;
    always_comb begin
        pad_cur = r_cur;
        if (r_p[WORD_BITS-1]) pad_cur = r_cur - CUR_ONE;
        else if (r_m[WORD_BITS-1]) pad_cur = r_cur + CUR_ONE;
    end

    logic pad_last;
    assign pad_last = (16'(r_i) + 16'd1 == pad);

    logic col_init;
    assign col_init = !i_rst_n || cfg_wr ||
                      (r_st == ST_IDLE && acc_in && i_req_type == REQ_END &&
                       pad == 16'd0) ||
                      (r_st == ST_PAD && !i_stall && r_olast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
            r_err <= '0;
        end else begin
            if (cfg_wr && paddr == ADDR_LEN) begin
                r_len <= pwdata[LEN_W-1:0];
            end
            if (cfg_wr && paddr == ADDR_ERR) begin
                r_err <= pwdata[ERR_W-1:0];
            end
            case (r_st)
                ST_IDLE: begin
                    r_ch   <= i_char_code[CW-1:0];
                    r_chok <= (32'(i_char_code) < ALPHABET);
                    r_b    <= '0;
                    r_pc   <= 1'b0;
                    r_mc   <= 1'b0;
                    if (acc_in) r_olast <= (pad == 16'd1);
                    if (acc_in && i_req_type == REQ_END) begin
                        r_act <= ({1'b0, r_sd} == (BW+1)'(used - 16'd1));
                        r_p   <= ({1'b0, r_sd} == (BW+1)'(used - 16'd1)) ? r_pv[r_sd] : '0;
                        r_m   <= ({1'b0, r_sd} == (BW+1)'(used - 16'd1)) ? r_mv[r_sd] : '0;
                        r_cur <= ({1'b0, r_sd} == (BW+1)'(used - 16'd1)) ?
                                 (SCORE_W+2)'(r_sc[r_sd]) : '0;
                        r_i   <= '0;
                        r_opos <= r_cnt[POS_W-1:0];
                    end
                end
                ST_BLOCK: begin
                    r_pv[bi] <= npv;
                    r_mv[bi] <= nmv;
                    r_last_old <= r_sc[bi];
                    r_pc <= bph[WORD_BITS-1];
                    r_mc <= !bph[WORD_BITS-1] && bmh[WORD_BITS-1];
                    if (bph[WORD_BITS-1]) begin
                        if (r_sc[bi] < SCORE_MAX) r_sc[bi] <= r_sc[bi] + 1'b1;
                    end else if (bmh[WORD_BITS-1]) begin
                        if (r_sc[bi] != '0) r_sc[bi] <= r_sc[bi] - 1'b1;
                    end
                    if (r_b != {1'b0, r_sd}) r_b <= r_b + 1'b1;
                    else r_b <= sd1;
                end
                ST_DECIDE: begin
                    r_opos <= r_cnt[POS_W-1:0];
                    r_olast <= 1'b1;
                    if (grow) begin
                        r_sd <= sd1[BW-1:0];
                        r_mv[sd1[BW-1:0]] <= WORD_BITS'(r_pc);
                        r_pv[sd1[BW-1:0]] <= r_mc ? MSK : (MSK << 1);
                        r_sc[sd1[BW-1:0]] <= SCORE_W'(r_err) + SCORE_W'(WORD_BITS - 1);
                        r_omatch <= (16'(sd1) == used - 16'd1) &&
                                    (SCORE_W'(r_err) + SCORE_W'(WORD_BITS - 1)
                                     <= SCORE_W'(r_err));
                    end else if (r_sc[r_sd] > SCORE_W'(lim) && r_sd != '0) begin
                        r_sd <= r_sd - 1'b1;
                    end else begin
                        r_omatch <= ({1'b0, r_sd} == (BW+1)'(used - 16'd1)) &&
                                    (r_sc[r_sd] <= SCORE_W'(r_err));
                    end
                end
                ST_OUT: begin
                    if (!i_stall) r_cnt <= r_cnt + 1'b1;
                end
                ST_PAD: begin
                    // r_olast follows pad_last for the row on offer
                    r_olast <= ((16'(r_i) + 16'd2 == pad) && !i_stall) ||
                               (pad_last && i_stall);
                    if (!i_stall) begin
                        r_cur <= pad_cur;
                        r_p <= r_p << 1;
                        r_m <= r_m << 1;
                        r_i <= r_i + 1'b1;
                        r_opos <= r_opos + 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (col_init) begin
            r_sd  <= sd_init[BW-1:0];
            r_cnt <= CNT_W'(1) - CNT_W'(pad);
            for (int b = 0; b < BLOCKS; b++) begin
                r_pv[b] <= MSK;
                r_mv[b] <= '0;
                r_sc[b] <= SCORE_W'((b + 1) * WORD_BITS);
            end
        end
    end

    // pad outputs are combinational off registered row state
    always_comb begin
        if (r_st == ST_PAD) begin
            o_match_found = r_act && (pad_cur <= $signed((SCORE_W+2)'(r_err)));
            o_last_result = pad_last;
        end else begin
            o_match_found = r_omatch;
            o_last_result = r_olast;
        end
    end
    assign o_text_position = r_opos;

    a_out_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken during output");
    a_sd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        16'(r_sd) < used || r_st != ST_IDLE || cfg_wr || $past(cfg_wr))
        else $error("active block past used");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT && i_stall) |=> (r_st == ST_OUT))
        else $error("result dropped");
endmodule

// ===== hw/rtl/bvam_table.sv =====
// ----------------------------------------------------------------------------
// bvam_table
// Match table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bvam_table
    import bvam_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int DEPTH     = ALPHABET_DEF * BLOCKS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WORD_BITS-1:0]     i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WORD_BITS-1:0]     o_rdata
);
    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
